// ----- hdl/knn_topk_rank_weighted_vote_top_assert.svh -----
// assertion macros used by the checker file hdl/knnv_checker.sv
`ifndef KNN_TOPK_RANK_WEIGHTED_VOTE_TOP_ASSERT_SVH
`define KNN_TOPK_RANK_WEIGHTED_VOTE_TOP_ASSERT_SVH

// clocked check, off while reset is high
`define KNNV_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error(msg);

// clocked check that also holds during reset
`define KNNV_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error(msg);

`endif

// ----- hdl/knnv_pkg.sv -----
package knnv_pkg;

  localparam int MAX_NEIGHBORS = 8;
  localparam int NUM_CLASSES   = 10;

  localparam int SCORE_W = 20;
  localparam int LABEL_W = 4;
  localparam int K_W     = 4;
  localparam int VOTES_W = 6;
  localparam int CNT_W   = $clog2(MAX_NEIGHBORS + 1);
  localparam int CLASS_W = $clog2(NUM_CLASSES);

  localparam logic [K_W-1:0] K_RESET = K_W'(5);
  localparam int VOTES_MAX = MAX_NEIGHBORS * (MAX_NEIGHBORS + 1) / 2;

  typedef struct packed {
    logic ins;
    logic drain;
  } cell_ctl_t;

endpackage

// ----- hdl/knnv_cell.sv -----
module knnv_cell (
  input  logic                         clk,
  input  knnv_pkg::cell_ctl_t          ctl,
  input  logic [knnv_pkg::SCORE_W-1:0] in_score,
  input  logic [knnv_pkg::LABEL_W-1:0] in_label,
  input  logic                         occupied,
  input  logic                         left_gt,
  input  logic [knnv_pkg::SCORE_W-1:0] left_score,
  input  logic [knnv_pkg::LABEL_W-1:0] left_label,
  input  logic [knnv_pkg::SCORE_W-1:0] right_score,
  input  logic [knnv_pkg::LABEL_W-1:0] right_label,
  output logic                         gt,
  output logic [knnv_pkg::SCORE_W-1:0] score,
  output logic [knnv_pkg::LABEL_W-1:0] label
);

  // empty slots act as infinitely far; equal scores keep the older entry ahead
  assign gt = !occupied || (score > in_score);

  always_ff @(posedge clk) begin
    if (ctl.ins && gt) begin
      if (left_gt) begin
        score <= left_score;
        label <= left_label;
      end else begin
        score <= in_score;
        label <= in_label;
      end
    end else if (ctl.drain) begin
      score <= right_score;
      label <= right_label;
    end
  end

endmodule

// ----- hdl/knnv_vote.sv -----
module knnv_vote (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [knnv_pkg::CNT_W-1:0]   start_count,
  input  logic [knnv_pkg::K_W-1:0]     start_k,
  input  logic [knnv_pkg::LABEL_W-1:0] head_label,
  input  logic                         out_ready,
  output logic                         drain,
  output logic                         busy,
  output logic                         out_valid,
  output logic [knnv_pkg::LABEL_W-1:0] voted_class,
  output logic [knnv_pkg::VOTES_W-1:0] winning_votes,
  output logic [knnv_pkg::CNT_W-1:0]   neighbors_held
);

  typedef enum logic [3:0] {
    V_IDLE = 4'b0001,
    V_ACC  = 4'b0010,
    V_SCAN = 4'b0100,
    V_DONE = 4'b1000
  } vote_state_t;

  vote_state_t                  state;
  logic [knnv_pkg::CNT_W-1:0]   rank;
  logic [knnv_pkg::CNT_W-1:0]   count;
  logic [knnv_pkg::K_W-1:0]     kk;
  logic [knnv_pkg::CLASS_W-1:0] cls;
  logic [knnv_pkg::CLASS_W-1:0] best;
  logic [knnv_pkg::VOTES_W-1:0] best_v;
  logic [knnv_pkg::VOTES_W-1:0] votes [knnv_pkg::NUM_CLASSES];
  logic [knnv_pkg::K_W-1:0]     weight;

  assign weight = kk - knnv_pkg::K_W'(rank);
  assign drain  = (state == V_ACC);
  assign busy   = (state != V_IDLE);

  // one tally per class, each bumped when the head label matches it
  always_ff @(posedge clk) begin
    for (int j = 0; j < knnv_pkg::NUM_CLASSES; j++) begin
      if (start) begin
        votes[j] <= '0;
      end else if (state == V_ACC && head_label == knnv_pkg::LABEL_W'(j)) begin
        votes[j] <= votes[j] + knnv_pkg::VOTES_W'(weight);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= V_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == V_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        V_IDLE: begin
          if (start) begin
            rank   <= '0;
            count  <= start_count;
            kk     <= start_k;
            cls    <= '0;
            best   <= '0;
            best_v <= '0;
            state  <= (start_count == '0) ? V_SCAN : V_ACC;
          end
        end
        V_ACC: begin
          rank <= rank + 1'b1;
          if (rank == count - 1'b1) begin
            state <= V_SCAN;
          end
        end
        V_SCAN: begin
          if (votes[cls] > best_v) begin
            best   <= cls;
            best_v <= votes[cls];
          end
          cls <= cls + 1'b1;
          if (cls == knnv_pkg::CLASS_W'(knnv_pkg::NUM_CLASSES - 1)) begin
            state <= V_DONE;
          end
        end
        V_DONE: begin
          if (!out_valid || out_ready) begin
            voted_class    <= knnv_pkg::LABEL_W'(best);
            winning_votes  <= best_v;
            neighbors_held <= count;
            state          <= V_IDLE;
          end
        end
        default: state <= V_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/knn_topk_rank_weighted_vote_top.sv -----
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    score, label, last
// out       output     out_valid / out_ready  voted_class, winning_votes, neighbors_held
// cfg       input      cfg_wr_en              cfg_wr_data (k_neighbors)
//
// a request without last is sorted into the cell row; one per cycle while in_ready is high
// a request with last is inserted, then the vote drains the row into the tally
// and scans every class for the argmax
// in_ready is low during the vote; a result waiting on out_ready stalls only the next vote
// rst is synchronous: list empty, k_neighbors back to 5, no result pending
module knn_topk_rank_weighted_vote_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [knnv_pkg::SCORE_W-1:0] score,
  input  logic [knnv_pkg::LABEL_W-1:0] label,
  input  logic                         last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [knnv_pkg::LABEL_W-1:0] voted_class,
  output logic [knnv_pkg::VOTES_W-1:0] winning_votes,
  output logic [knnv_pkg::CNT_W-1:0]   neighbors_held,
  input  logic                         cfg_wr_en,
  input  logic [knnv_pkg::K_W-1:0]     cfg_wr_data
);

  localparam int N = knnv_pkg::MAX_NEIGHBORS;

  logic [knnv_pkg::K_W-1:0]     k_neighbors;
  logic [knnv_pkg::K_W-1:0]     k_eff;
  logic [knnv_pkg::CNT_W-1:0]   k_cnt;
  logic [knnv_pkg::CNT_W-1:0]   held_count;
  logic [knnv_pkg::CNT_W-1:0]   held_eff;
  logic [knnv_pkg::CNT_W-1:0]   held_next;
  logic                         accept;
  logic                         busy;
  logic                         drain;
  knnv_pkg::cell_ctl_t          ctl;

  logic                         gt        [N];
  logic [knnv_pkg::SCORE_W-1:0] cell_score [N];
  logic [knnv_pkg::LABEL_W-1:0] cell_label [N];

  always_comb begin
    if (k_neighbors == '0) begin
      k_eff = knnv_pkg::K_W'(1);
    end else if (k_neighbors > knnv_pkg::K_W'(N)) begin
      k_eff = knnv_pkg::K_W'(N);
    end else begin
      k_eff = k_neighbors;
    end
  end

  assign k_cnt     = knnv_pkg::CNT_W'(k_eff);
  // k lowered mid-query: only the nearest k entries count
  assign held_eff  = (held_count > k_cnt) ? k_cnt : held_count;
  assign held_next = (held_eff < k_cnt) ? held_eff + 1'b1 : held_eff;

  assign in_ready  = !busy;
  assign accept    = in_valid && in_ready;
  assign ctl.ins   = accept;
  assign ctl.drain = drain;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_neighbors <= knnv_pkg::K_RESET;
      held_count  <= '0;
    end else begin
      if (cfg_wr_en) begin
        k_neighbors <= cfg_wr_data;
      end
      if (accept) begin
        held_count <= last ? '0 : held_next;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                         l_gt;
    logic [knnv_pkg::SCORE_W-1:0] l_score;
    logic [knnv_pkg::LABEL_W-1:0] l_label;
    logic [knnv_pkg::SCORE_W-1:0] r_score;
    logic [knnv_pkg::LABEL_W-1:0] r_label;

    if (i == 0) begin : g_head
      assign l_gt    = 1'b0;
      assign l_score = '0;
      assign l_label = '0;
    end else begin : g_body
      assign l_gt    = gt[i-1];
      assign l_score = cell_score[i-1];
      assign l_label = cell_label[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign r_score = '0;
      assign r_label = '0;
    end else begin : g_mid
      assign r_score = cell_score[i+1];
      assign r_label = cell_label[i+1];
    end

    knnv_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .in_score    (score),
      .in_label    (label),
      .occupied    (knnv_pkg::CNT_W'(i) < held_eff),
      .left_gt     (l_gt),
      .left_score  (l_score),
      .left_label  (l_label),
      .right_score (r_score),
      .right_label (r_label),
      .gt          (gt[i]),
      .score       (cell_score[i]),
      .label       (cell_label[i])
    );
  end

  knnv_vote u_vote (
    .clk            (clk),
    .rst            (rst),
    .start          (accept && last),
    .start_count    (held_next),
    .start_k        (k_eff),
    .head_label     (cell_label[0]),
    .out_ready      (out_ready),
    .drain          (drain),
    .busy           (busy),
    .out_valid      (out_valid),
    .voted_class    (voted_class),
    .winning_votes  (winning_votes),
    .neighbors_held (neighbors_held)
  );

endmodule

// ----- hdl/knnv_checker.sv -----
`include "knn_topk_rank_weighted_vote_top_assert.svh"

module knnv_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         last,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [knnv_pkg::LABEL_W-1:0] voted_class,
  input logic [knnv_pkg::VOTES_W-1:0] winning_votes,
  input logic [knnv_pkg::CNT_W-1:0]   neighbors_held
);

  // a last request starts the vote, which blocks new requests
  `KNNV_ASSERT(a_vote_blocks, clk, rst, in_valid && in_ready && last |=> !in_ready, "input taken during vote")

  `KNNV_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(voted_class) && $stable(winning_votes) && $stable(neighbors_held), "result changed while stalled")

  `KNNV_ASSERT_ALWAYS(a_out_range, clk, out_valid |-> (winning_votes <= knnv_pkg::VOTES_W'(knnv_pkg::VOTES_MAX)) && (neighbors_held <= knnv_pkg::CNT_W'(knnv_pkg::MAX_NEIGHBORS)) && (voted_class < knnv_pkg::LABEL_W'(knnv_pkg::NUM_CLASSES)), "result out of range")

  // no votes anywhere means class 0 wins
  `KNNV_ASSERT(a_zero_votes, clk, rst, out_valid && winning_votes == '0 |-> voted_class == '0, "empty vote picked nonzero class")

endmodule

bind knn_topk_rank_weighted_vote_top knnv_checker u_knnv_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .last           (last),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .voted_class    (voted_class),
  .winning_votes  (winning_votes),
  .neighbors_held (neighbors_held)
);

// ----- tb/sv/knn_topk_rank_weighted_vote_checker.sv -----
module knn_topk_rank_weighted_vote_checker
  import knnv_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [SCORE_W-1:0] score,
  input  logic [LABEL_W-1:0] label,
  input  logic               last,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [LABEL_W-1:0] voted_class,
  input  logic [VOTES_W-1:0] winning_votes,
  input  logic [CNT_W-1:0]   neighbors_held,
  input  logic               cfg_wr_en,
  input  logic [K_W-1:0]     cfg_wr_data,
  output int                 error_count,
  output int                 votes_pending,
  output int                 votes_checked
);

  typedef struct packed {
    logic [LABEL_W-1:0] cls;
    logic [VOTES_W-1:0] total;
    logic [CNT_W-1:0]   held;
  } vote_t;

  logic [SCORE_W-1:0] near_score [MAX_NEIGHBORS];
  logic [LABEL_W-1:0] near_label [MAX_NEIGHBORS];
  int                 list_len;
  logic [K_W-1:0]     k_setting;
  vote_t              pending_votes_q [$];

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    error_count++;
  endtask

  // zero acts as one, anything past the list depth acts as the full depth
  function automatic int active_k();
    if (k_setting == '0) return 1;
    if (k_setting > MAX_NEIGHBORS) return MAX_NEIGHBORS;
    return int'(k_setting);
  endfunction

  function automatic void rank_candidate(input logic [SCORE_W-1:0] s,
                                         input logic [LABEL_W-1:0] l, input int k);
    int p;
    if (list_len < k) begin
      p = list_len;
      list_len++;
    end else if (s < near_score[k-1]) begin
      p = k - 1;
    end else begin
      return;
    end
    // strict compare keeps earlier equal scores in front
    while (p > 0 && near_score[p-1] > s) begin
      near_score[p] = near_score[p-1];
      near_label[p] = near_label[p-1];
      p--;
    end
    near_score[p] = s;
    near_label[p] = l;
  endfunction

  function automatic vote_t cast_vote(input int k);
    int    tally [NUM_CLASSES];
    int    best;
    vote_t v;
    foreach (tally[c]) tally[c] = 0;
    for (int i = 0; i < list_len; i++) begin
      if (near_label[i] < NUM_CLASSES) tally[near_label[i]] += k - i;
    end
    best = 0;
    for (int c = 1; c < NUM_CLASSES; c++) begin
      if (tally[c] > tally[best]) best = c;
    end
    v.cls   = LABEL_W'(best);
    v.total = VOTES_W'(tally[best]);
    v.held  = CNT_W'(list_len);
    return v;
  endfunction

  always @(posedge clk) begin
    vote_t want;
    int    k;
    if (rst) begin
      list_len  = 0;
      k_setting = K_RESET;
      pending_votes_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_votes_q.size() == 0) begin
          report_mismatch($sformatf("vote for class %0d with no query closed", voted_class));
        end else begin
          want = pending_votes_q.pop_front();
          votes_checked++;
          if (voted_class !== want.cls)
            report_mismatch($sformatf("voted_class got %0d expected %0d",
                                      voted_class, want.cls));
          if (winning_votes !== want.total)
            report_mismatch($sformatf("winning_votes got %0d expected %0d",
                                      winning_votes, want.total));
          if (neighbors_held !== want.held)
            report_mismatch($sformatf("neighbors_held got %0d expected %0d",
                                      neighbors_held, want.held));
        end
      end
      if (cfg_wr_en) k_setting = cfg_wr_data;
      if (in_valid && in_ready) begin
        k = active_k();
        // a lowered k trims the list before the new request goes in
        if (list_len > k) list_len = k;
        rank_candidate(score, label, k);
        if (last) begin
          pending_votes_q.push_back(cast_vote(k));
          list_len = 0;
        end
      end
    end
    votes_pending = pending_votes_q.size();
  end

endmodule

// ----- tb/sv/knn_topk_rank_weighted_vote_top_tb.sv -----
module knn_topk_rank_weighted_vote_top_tb;
  import knnv_pkg::*;

  localparam int STALL_PCT      = 16;
  localparam int SETTLE_CYCLES  = 30;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 100;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic [SCORE_W-1:0] score       = '0;
  logic [LABEL_W-1:0] label       = '0;
  logic               last        = 1'b0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic [LABEL_W-1:0] voted_class;
  logic [VOTES_W-1:0] winning_votes;
  logic [CNT_W-1:0]   neighbors_held;
  logic               cfg_wr_en   = 1'b0;
  logic [K_W-1:0]     cfg_wr_data = '0;

  logic no_stall        = 1'b0;
  int   error_count;
  int   votes_pending;
  int   votes_checked;
  int   candidates_sent = 0;
  int   idle_cycles     = 0;

  knn_topk_rank_weighted_vote_top u_dut (.*);

  knn_topk_rank_weighted_vote_checker u_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready = no_stall || ($urandom_range(0, 99) >= STALL_PCT);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", idle_cycles);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_candidate(input logic [SCORE_W-1:0] s, input logic [LABEL_W-1:0] l,
                                input logic lst);
    while (!no_stall && $urandom_range(0, 99) < STALL_PCT) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    score    = s;
    label    = l;
    last     = lst;
    do @(posedge clk); while (!in_ready);
    candidates_sent++;
  endtask

  // hold off until every vote is back and the list logic has gone quiet
  task automatic wait_quiet();
    @(negedge clk);
    in_valid = 1'b0;
    while (votes_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_k(input logic [K_W-1:0] v);
    wait_quiet();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // many small scores so ties and refusals at the worst slot are common
  function automatic logic [SCORE_W-1:0] pick_score();
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 4) return SCORE_W'($urandom_range(0, 31));
    if (mode == 4) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return SCORE_W'($urandom);
  endfunction

  function automatic logic [LABEL_W-1:0] pick_label();
    if ($urandom_range(0, 99) < 85) return LABEL_W'($urandom_range(0, NUM_CLASSES - 1));
    return LABEL_W'($urandom_range(NUM_CLASSES, 15));
  endfunction

  task automatic send_query(input int len, input bit cut_midway);
    for (int i = 0; i < len; i++) begin
      if (cut_midway && i == len / 2) write_k(K_W'($urandom_range(0, 15)));
      send_candidate(pick_score(), pick_label(), i == len - 1);
    end
  endtask

  initial begin
    logic [K_W-1:0] phase_k [6];
    int             qlen;
    int             phase_start;
    phase_k = '{4'd8, 4'd1, 4'd4, 4'd15, 4'd0, 4'd6};
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // k from reset: fill, equal scores, displace the worst, equal to worst refused
    send_candidate('1, 4'd0, 1'b0);
    send_candidate('0, 4'd15, 1'b0);
    send_candidate(20'd100, 4'd3, 1'b0);
    send_candidate(20'd100, 4'd4, 1'b0);
    send_candidate(20'd100, 4'd3, 1'b0);
    send_candidate(20'd50, 4'd9, 1'b0);
    send_candidate(20'd100, 4'd2, 1'b1);
    send_candidate(20'd12345, 4'd9, 1'b1);

    // lower k with four held so the list gets cut before the last request
    write_k(4'd8);
    send_candidate(20'd7, 4'd1, 1'b0);
    send_candidate(20'd3, 4'd2, 1'b0);
    send_candidate(20'd9, 4'd1, 1'b0);
    send_candidate(20'd1, 4'd3, 1'b0);
    write_k(4'd2);
    send_candidate(20'd2, 4'd5, 1'b1);

    write_k(4'd0);
    send_candidate(20'd5, 4'd7, 1'b0);
    send_candidate(20'd4, 4'd8, 1'b1);

    write_k(4'd15);
    for (int i = 0; i < 9; i++) begin
      send_candidate(SCORE_W'(20'hFFFFF - i * 3), LABEL_W'(i + 6), i == 8);
    end

    for (int p = 0; p < 6; p++) begin
      write_k(phase_k[p]);
      no_stall    = (p == 2);
      phase_start = candidates_sent;
      while (candidates_sent - phase_start < PHASE_ITEMS) begin
        qlen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        send_query(qlen, $urandom_range(0, 19) == 0);
      end
    end
    no_stall = 1'b0;

    wait_quiet();
    $display("covered %0d candidates and %0d checked votes over k settings 0 to 15",
             candidates_sent, votes_checked);
    $display("with ties, labels past the class range and k cuts in the middle of a query");
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- knn_topk_rank_weighted_vote_top.f -----
+incdir+hdl
hdl/knnv_pkg.sv
hdl/knnv_cell.sv
hdl/knnv_vote.sv
hdl/knn_topk_rank_weighted_vote_top.sv
hdl/knnv_checker.sv
tb/sv/knn_topk_rank_weighted_vote_checker.sv
tb/sv/knn_topk_rank_weighted_vote_top_tb.sv
